FILE: sv/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define BMG_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BMG_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BMG_ASSERT(name, clk, rst_n, prop, msg)
`define BMG_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

FILE: sv/bmg_pkg.sv
package bmg_pkg;

  typedef struct packed {
    logic [31:0] radius_word;
    logic [31:0] angle_word;
  } bmg_req_t;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               saturated_flag;
  } bmg_rsp_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_MEAN_VALUE     = 2'd0;
  localparam logic [1:0] CFG_STD_DEVIATION  = 2'd1;
  localparam logic [1:0] CFG_ZERO_THRESHOLD = 2'd2;

  localparam logic [31:0] MEAN_RESET      = 32'd0;
  localparam logic [30:0] STD_RESET       = 31'd16777216;
  localparam logic [31:0] THRESHOLD_RESET = 32'd4295;

  localparam logic [30:0] ONE_Q30        = 31'h4000_0000;
  localparam logic [30:0] TWO_LN2_Q30    = 31'd1488522236;
  localparam logic [29:0] QUARTER_PI_Q30 = 30'd843314857;
  localparam logic [29:0] OCT_ONE        = 30'h2000_0000;

  // Taylor term divisors, innermost first
  localparam int unsigned COS_DIV [5] = '{90, 56, 30, 12, 2};
  localparam int unsigned SIN_DIV [4] = '{72, 42, 20, 6};

  // Pipeline layout: register stage indexes
  localparam int unsigned LOG_ROUNDS  = 28;
  localparam int unsigned ST_LOG_T    = 29;
  localparam int unsigned ST_SQRT_IN  = 30;
  localparam int unsigned ROOT_BITS   = 31;
  localparam int unsigned ST_ROOT     = 61;
  localparam int unsigned ST_ANGLE    = 12;
  localparam int unsigned ANGLE_DELAY = ST_ROOT - ST_ANGLE;
  localparam int unsigned NUM_STAGES  = 65;

endpackage

FILE: sv/box_muller_gaussian_sampler_unit.sv
// Box-Muller Gaussian sampler: each request carries two raw uniform words and yields
// one signed Q8.24 sample, mean + sigma * sqrt(-2 ln u1) * cos(2 pi u2), saturated to
// the 32-bit range with a flag. A request whose radius word is zero or below the zero
// threshold is dropped and gives no result. The pipeline is 65 stages deep and takes
// one request per clock while its output is not stalled. The 28 log2 squaring rounds
// and the 31 square root bit steps set that depth. A stalled output holds every stage
// in place. Configuration must be written by the user only while the pipeline is
// empty; the block itself does not enforce it.
module box_muller_gaussian_sampler_unit import bmg_pkg::*; #(
  parameter int unsigned RANDOM_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  bmg_req_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output bmg_rsp_t    out_data_o
);

  `include "assert_macros.svh"

  logic [31:0] mean_q;
  logic [30:0] std_q;
  logic [31:0] thr_q;

  logic [NUM_STAGES-1:0] v_q;
  logic                  adv;
  logic [31:0]           rm;
  logic                  reject;

  logic [30:0] root;
  logic [30:0] cosv;
  logic        neg;

  logic [61:0] zp;
  logic [30:0] zm_q;
  logic [61:0] pr_q;
  logic [1:0]  neg_q;
  logic [62:0] pp;
  logic [36:0] ms;
  logic [36:0] pv;
  logic [36:0] sum;
  logic        sat_hi;
  logic        sat_lo;
  bmg_rsp_t    out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= MEAN_RESET;
      std_q  <= STD_RESET;
      thr_q  <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MEAN_VALUE:     mean_q <= cfg_wdata_i;
        CFG_STD_DEVIATION:  std_q  <= cfg_wdata_i[30:0];
        CFG_ZERO_THRESHOLD: thr_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless the result register is held
  assign adv        = !v_q[NUM_STAGES-1] || out_ready_i;
  assign in_ready_o = adv;

  assign rm     = (in_data_i.radius_word << (32 - RANDOM_BITS)) >> (32 - RANDOM_BITS);
  assign reject = (rm == '0) || (rm < thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NUM_STAGES-2:0], in_valid_i && !reject};
    end
  end

  bmg_radius #(.RANDOM_BITS(RANDOM_BITS)) u_radius (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .word_i (in_data_i.radius_word),
    .root_o (root)
  );

  bmg_angle #(.RANDOM_BITS(RANDOM_BITS)) u_angle (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .word_i (in_data_i.angle_word),
    .cos_o  (cosv),
    .neg_o  (neg)
  );

  assign zp  = 62'(root) * 62'(cosv);
  assign pp  = 63'(pr_q) + (63'd1 << 27);
  assign ms  = {{5{mean_q[31]}}, mean_q};
  assign pv  = {2'b00, pp[62:28]};
  assign sum = neg_q[1] ? ms - pv : ms + pv;
  // Clip anything outside the signed 32-bit range
  assign sat_hi = !sum[36] && (sum[35:31] != '0);
  assign sat_lo = sum[36] && (sum[35:31] != '1);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zm_q     <= zp[60:30];
      neg_q[0] <= neg;
      pr_q     <= 62'(std_q) * 62'(zm_q);
      neg_q[1] <= neg_q[0];
      out_q.saturated_flag <= sat_hi || sat_lo;
      if (sat_hi) begin
        out_q.sample_value <= 32'sh7FFF_FFFF;
      end else if (sat_lo) begin
        out_q.sample_value <= 32'sh8000_0000;
      end else begin
        out_q.sample_value <= signed'(sum[31:0]);
      end
    end
  end

  assign out_valid_o = v_q[NUM_STAGES-1];
  assign out_data_o  = out_q;

  `BMG_ASSERT(a_sat_at_end, clk_i, rst_ni, (out_valid_o && out_data_o.saturated_flag) |-> (out_data_o.sample_value == 32'sh7FFF_FFFF || out_data_o.sample_value == 32'sh8000_0000), "saturated sample not at a range end")
  `BMG_ASSERT(a_drop_reject, clk_i, rst_ni, (in_valid_i && in_ready_o && reject) |=> !v_q[0], "rejected request entered the pipeline")
  `BMG_ASSERT(a_last_reaches_out, clk_i, rst_ni, (adv && v_q[NUM_STAGES-2]) |=> out_valid_o, "request lost before the result register")
  `BMG_ASSERT(a_hold_on_stall, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> $stable(v_q), "pipeline moved while the result was held")

endmodule

FILE: sv/bmg_radius.sv
module bmg_radius import bmg_pkg::*; #(
  parameter int unsigned RANDOM_BITS = 32
) (
  input  logic        clk_i,
  input  logic        adv_i,
  input  logic [31:0] word_i,
  output logic [30:0] root_o
);

  logic [31:0] rm;
  logic [4:0]  msb;
  logic [31:0] x0;

  logic [31:0] x_q [LOG_ROUNDS+1];
  logic [4:0]  e_q [LOG_ROUNDS+1];
  logic [27:0] f_q [LOG_ROUNDS+1];
  logic [31:0] x_d [LOG_ROUNDS+1];
  logic [27:0] f_d [LOG_ROUNDS+1];

  logic [33:0] t_q;
  logic [5:0]  int_part;
  logic [33:0] t_d;
  logic [64:0] wp;

  logic [63:0] rem_q [ROOT_BITS+1];
  logic [30:0] root_q [ROOT_BITS+1];
  logic [63:0] rem_d [ROOT_BITS+1];
  logic [30:0] root_d [ROOT_BITS+1];

  // Normalize the masked word so that its leading one sits at bit 31
  always_comb begin
    rm  = (word_i << (32 - RANDOM_BITS)) >> (32 - RANDOM_BITS);
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (rm[i]) msb = 5'(i);
    end
    x0 = rm << (5'd31 - msb);
  end

  // One squaring per stage; an overflow past 2.0 yields one fraction bit
  always_comb begin
    logic [63:0] sq;
    sq     = '0;
    x_d[0] = x0;
    f_d[0] = '0;
    for (int k = 1; k <= LOG_ROUNDS; k++) begin
      sq     = 64'(x_q[k-1]) * 64'(x_q[k-1]);
      f_d[k] = f_q[k-1];
      f_d[k][LOG_ROUNDS-k] = sq[63];
      x_d[k] = sq[63] ? sq[63:32] : sq[62:31];
    end
  end

  assign int_part = 6'(RANDOM_BITS) - {1'b0, e_q[LOG_ROUNDS]};
  assign t_d      = {int_part, 28'd0} - {6'd0, f_q[LOG_ROUNDS]};
  assign wp       = 65'(t_q) * 65'(TWO_LN2_Q30);

  // Digit-by-digit square root, one result bit per stage
  always_comb begin
    logic [63:0] trial;
    trial     = '0;
    rem_d[0]  = {2'b00, wp[63:30], 28'd0};
    root_d[0] = '0;
    for (int j = 0; j < ROOT_BITS; j++) begin
      trial = (64'(root_q[j]) << (ROOT_BITS - j)) | (64'd1 << (2 * (ROOT_BITS - 1 - j)));
      rem_d[j+1]  = rem_q[j];
      root_d[j+1] = root_q[j];
      if (rem_q[j] >= trial) begin
        rem_d[j+1] = rem_q[j] - trial;
        root_d[j+1][ROOT_BITS-1-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k <= LOG_ROUNDS; k++) begin
        x_q[k] <= x_d[k];
        f_q[k] <= f_d[k];
        e_q[k] <= (k == 0) ? msb : e_q[k-1];
      end
      t_q <= t_d;
      for (int j = 0; j <= ROOT_BITS; j++) begin
        rem_q[j]  <= rem_d[j];
        root_q[j] <= root_d[j];
      end
    end
  end

  assign root_o = root_q[ROOT_BITS];

endmodule

FILE: sv/bmg_hstep.sv
module bmg_hstep import bmg_pkg::*; #(
  parameter int unsigned DIV = 2
) (
  input  logic        clk_i,
  input  logic        adv_i,
  input  logic [29:0] x2_i,
  input  logic [30:0] t_i,
  output logic [30:0] t_o
);

  localparam int unsigned SH    = 30 + $clog2(DIV);
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);

  logic [60:0] mp;
  logic [30:0] m_q;
  logic [63:0] qp;
  logic [63:0] quo;
  logic [30:0] t_q;

  assign mp  = 61'(x2_i) * 61'(t_i);
  // Exact floor division for numerators below 2^30
  assign qp  = 64'(m_q) * RECIP;
  assign quo = qp >> SH;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m_q <= mp[60:30];
      t_q <= ONE_Q30 - quo[30:0];
    end
  end

  assign t_o = t_q;

endmodule

FILE: sv/bmg_angle.sv
module bmg_angle import bmg_pkg::*; #(
  parameter int unsigned RANDOM_BITS = 32
) (
  input  logic        clk_i,
  input  logic        adv_i,
  input  logic [31:0] word_i,
  output logic [30:0] cos_o,
  output logic        neg_o
);

  logic [31:0] ph;
  logic [29:0] arg;
  logic [59:0] xp;
  logic [59:0] x2p;
  logic [60:0] sp;

  logic [29:0] x_q   [10];
  logic [29:0] x2_q  [1:9];
  logic [2:0]  oct_q [12];
  logic [30:0] ct    [5];
  logic [30:0] st    [4];
  logic [30:0] sin_q;
  logic [30:0] sin2_q;
  logic [30:0] ca;
  logic [30:0] sa;
  logic [30:0] c_q   [ANGLE_DELAY+1];
  logic        n_q   [ANGLE_DELAY+1];

  // Reduce to an octant, mirror odd octants, scale to radians
  assign ph  = word_i << (32 - RANDOM_BITS);
  assign arg = ph[29] ? (OCT_ONE - {1'b0, ph[28:0]}) : {1'b0, ph[28:0]};
  assign xp  = 60'(arg) * 60'(QUARTER_PI_Q30);
  assign x2p = 60'(x_q[0]) * 60'(x_q[0]);
  assign sp  = 61'(x_q[9]) * 61'(st[3]);

  for (genvar j = 0; j < 5; j++) begin : g_cos
    bmg_hstep #(.DIV(COS_DIV[j])) u_step (
      .clk_i (clk_i),
      .adv_i (adv_i),
      .x2_i  (x2_q[1+2*j]),
      .t_i   ((j == 0) ? ONE_Q30 : ct[(j == 0) ? 0 : j-1]),
      .t_o   (ct[j])
    );
  end

  for (genvar j = 0; j < 4; j++) begin : g_sin
    bmg_hstep #(.DIV(SIN_DIV[j])) u_step (
      .clk_i (clk_i),
      .adv_i (adv_i),
      .x2_i  (x2_q[1+2*j]),
      .t_i   ((j == 0) ? ONE_Q30 : st[(j == 0) ? 0 : j-1]),
      .t_o   (st[j])
    );
  end

  assign ca = oct_q[11][0] ? sin2_q : ct[4];
  assign sa = oct_q[11][0] ? ct[4] : sin2_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0]   <= xp[58:29];
      oct_q[0] <= ph[31:29];
      x2_q[1]  <= x2p[59:30];
      for (int k = 1; k < 10; k++) begin
        x_q[k] <= x_q[k-1];
      end
      for (int k = 2; k < 10; k++) begin
        x2_q[k] <= x2_q[k-1];
      end
      for (int k = 1; k < 12; k++) begin
        oct_q[k] <= oct_q[k-1];
      end
      sin_q  <= sp[60:30];
      sin2_q <= sin_q;
      // Quadrants 1 and 3 take the other function; 1 and 2 are negative
      c_q[0] <= oct_q[11][1] ? sa : ca;
      n_q[0] <= oct_q[11][2] ^ oct_q[11][1];
      for (int k = 1; k <= ANGLE_DELAY; k++) begin
        c_q[k] <= c_q[k-1];
        n_q[k] <= n_q[k-1];
      end
    end
  end

  assign cos_o = c_q[ANGLE_DELAY];
  assign neg_o = n_q[ANGLE_DELAY];

endmodule
